>>> hw/rtl/bavg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bavg_pkg
// Shared constants and types for the XY block averaging downsampler.
// ----------------------------------------------------------------------------
package bavg_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_FACTOR   = 16;
    localparam int SAMPLE_BITS  = 16;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int FRAC_BITS    = 8;
    localparam int MEAN_W       = 24;

    localparam int POS_W    = $clog2(MAX_WIDTH);
    localparam int DIM_W    = $clog2(MAX_WIDTH + 1);
    localparam int HPOS_W   = $clog2(HEIGHT_LIMIT);
    localparam int HDIM_W   = $clog2(HEIGHT_LIMIT + 1);
    localparam int CIB_W    = $clog2(MAX_FACTOR);
    localparam int FACTOR_W = $clog2(MAX_FACTOR + 1);
    localparam int COUNT_W  = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
    localparam int SUM_W    = SAMPLE_BITS + 2 * $clog2(MAX_FACTOR);
    localparam int DVD_W    = SUM_W + FRAC_BITS;

    localparam int CFG_W0 = (DIM_W > HDIM_W) ? DIM_W : HDIM_W;
    localparam int CFG_W  = (CFG_W0 > FACTOR_W) ? CFG_W0 : FACTOR_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    // per-voxel bookkeeping handed from the position counters to the accumulator
    typedef struct packed {
        logic [POS_W-1:0]   addr;
        logic               first_row;
        logic               emit;
        logic               last_slice;
        logic [COUNT_W-1:0] count;
    } bavg_tag_t;

    // block sum handed to the divider
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [COUNT_W-1:0]      count;
        logic                    last;
    } bavg_div_req_t;

endpackage

>>> hw/rtl/bavg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bavg_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bavg_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/bavg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bavg_ctrl
// Configuration registers and raster position counters; tags each voxel.
// ----------------------------------------------------------------------------
module bavg_ctrl (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [bavg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bavg_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                             advance,
    output bavg_pkg::bavg_tag_t              tag
);
    import bavg_pkg::*;

    localparam int PROD_W = 2 * FACTOR_W;

    logic [FACTOR_W-1:0] factor_reg, factor_next;
    logic [DIM_W-1:0]    width_reg, width_next;
    logic [HDIM_W-1:0]   height_reg, height_next;
    logic [POS_W-1:0]    col_pos_reg, col_pos_next;
    logic [HPOS_W-1:0]   row_pos_reg, row_pos_next;
    logic [CIB_W-1:0]    cib_reg, cib_next;
    logic [CIB_W-1:0]    rib_reg, rib_next;
    logic [POS_W-1:0]    ocol_reg, ocol_next;

    logic [FACTOR_W-1:0] cib_inc, rib_inc, cols_min, rows_min;
    logic [DIM_W-1:0]    col_inc, cols;
    logic [HDIM_W-1:0]   row_inc, rows;
    logic [POS_W-1:0]    col_start;
    logic [HPOS_W-1:0]   row_start;
    logic                col_end, row_end, last_col, last_row, cfg_hit;
    logic [PROD_W-1:0]   prod;

    always_comb begin
        cib_inc   = FACTOR_W'(cib_reg) + FACTOR_W'(1);
        rib_inc   = FACTOR_W'(rib_reg) + FACTOR_W'(1);
        col_inc   = DIM_W'(col_pos_reg) + DIM_W'(1);
        row_inc   = HDIM_W'(row_pos_reg) + HDIM_W'(1);
        col_end   = col_inc >= width_reg;
        row_end   = row_inc >= height_reg;
        last_col  = (cib_inc >= factor_reg) || col_end;
        last_row  = (rib_inc >= factor_reg) || row_end;
        col_start = col_pos_reg - POS_W'(cib_reg);
        row_start = row_pos_reg - HPOS_W'(rib_reg);
        cols      = width_reg - DIM_W'(col_start);
        rows      = height_reg - HDIM_W'(row_start);
        cols_min  = (cols > DIM_W'(factor_reg)) ? factor_reg : FACTOR_W'(cols);
        rows_min  = (rows > HDIM_W'(factor_reg)) ? factor_reg : FACTOR_W'(rows);
        prod      = PROD_W'(cols_min) * PROD_W'(rows_min);

        tag.addr       = ocol_reg;
        tag.first_row  = (rib_reg == '0);
        tag.emit       = last_col && last_row;
        tag.last_slice = col_end && row_end;
        tag.count      = COUNT_W'(prod);
    end

    always_comb begin
        factor_next  = factor_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        cib_next     = cib_reg;
        rib_next     = rib_reg;
        ocol_next    = ocol_reg;
        cfg_hit      = 1'b0;

        if (cfg_we) begin
            case (cfg_index)
                REG_FACTOR: begin
                    cfg_hit = 1'b1;
                    if (cfg_wdata == '0) begin
                        factor_next = FACTOR_W'(1);
                    end else if (cfg_wdata > CFG_W'(MAX_FACTOR)) begin
                        factor_next = FACTOR_W'(MAX_FACTOR);
                    end else begin
                        factor_next = FACTOR_W'(cfg_wdata);
                    end
                end
                REG_WIDTH: begin
                    cfg_hit = 1'b1;
                    if (cfg_wdata == '0) begin
                        width_next = DIM_W'(1);
                    end else if (cfg_wdata > CFG_W'(MAX_WIDTH)) begin
                        width_next = DIM_W'(MAX_WIDTH);
                    end else begin
                        width_next = DIM_W'(cfg_wdata);
                    end
                end
                REG_HEIGHT: begin
                    cfg_hit = 1'b1;
                    if (cfg_wdata == '0) begin
                        height_next = HDIM_W'(1);
                    end else if (cfg_wdata > CFG_W'(HEIGHT_LIMIT)) begin
                        height_next = HDIM_W'(HEIGHT_LIMIT);
                    end else begin
                        height_next = HDIM_W'(cfg_wdata);
                    end
                end
                default: cfg_hit = 1'b0;
            endcase
        end

        if (cfg_hit) begin
            col_pos_next = '0;
            row_pos_next = '0;
            cib_next     = '0;
            rib_next     = '0;
            ocol_next    = '0;
        end else if (advance) begin
            if (cib_inc >= factor_reg) begin
                cib_next  = '0;
                ocol_next = ocol_reg + POS_W'(1);
            end else begin
                cib_next = CIB_W'(cib_inc);
            end
            col_pos_next = POS_W'(col_inc);
            if (col_end) begin
                col_pos_next = '0;
                cib_next     = '0;
                ocol_next    = '0;
                rib_next     = (rib_inc >= factor_reg) ? '0 : CIB_W'(rib_inc);
                row_pos_next = row_end ? '0 : HPOS_W'(row_inc);
                if (row_end) begin
                    rib_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            factor_reg  <= FACTOR_W'(1);
            width_reg   <= DIM_W'(MAX_WIDTH);
            height_reg  <= HDIM_W'(HEIGHT_LIMIT);
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            cib_reg     <= '0;
            rib_reg     <= '0;
            ocol_reg    <= '0;
        end else begin
            factor_reg  <= factor_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
            cib_reg     <= cib_next;
            rib_reg     <= rib_next;
            ocol_reg    <= ocol_next;
        end
    end

`ifndef SYNTHESIS
    a_cib_in_block: assert property (@(posedge aclk) disable iff (!aresetn)
        FACTOR_W'(cib_reg) < factor_reg)
        else $error("column-in-block counter reached the factor");

    a_ocol_behind_col: assert property (@(posedge aclk) disable iff (!aresetn)
        ocol_reg <= col_pos_reg)
        else $error("output column ahead of column position");
`endif

endmodule

>>> hw/rtl/bavg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bavg_div
// Radix-2 restoring divider for block mean, with registered result port.
// ----------------------------------------------------------------------------
module bavg_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              req_valid,
    input  bavg_pkg::bavg_div_req_t           req,
    output logic                              req_ready,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [bavg_pkg::MEAN_W-1:0] m_mean_value,
    output logic                              m_last_in_slice
);
    import bavg_pkg::*;

    localparam int DIV_STEPS = DVD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int REM_W     = COUNT_W + 1;

    typedef enum logic [1:0] {IDLE, BUSY, DONE} state_t;

    state_t               state_reg;
    logic [DVD_W-1:0]     dvd_reg;
    logic [COUNT_W-1:0]   rem_reg;
    logic [COUNT_W-1:0]   den_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 neg_reg;
    logic                 last_reg;
    logic signed [MEAN_W-1:0] mean_reg;

    logic [SUM_W-1:0]        mag;
    logic [REM_W-1:0]        rem_sh;
    logic                    fits;
    logic [COUNT_W-1:0]      rem_nx;
    logic [DVD_W-1:0]        dvd_nx;
    logic signed [DVD_W:0]   q_s;
    logic signed [DVD_W-1:0] scaled;

    always_comb begin
        mag    = req.sum[SUM_W-1] ? SUM_W'(-req.sum) : SUM_W'(req.sum);
        scaled = {req.sum, {FRAC_BITS{1'b0}}};
        rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
        fits   = rem_sh >= REM_W'(den_reg);
        rem_nx = fits ? COUNT_W'(rem_sh - REM_W'(den_reg)) : COUNT_W'(rem_sh);
        dvd_nx = {dvd_reg[DVD_W-2:0], fits};
        q_s    = neg_reg ? -signed'({1'b0, dvd_nx}) : signed'({1'b0, dvd_nx});
    end

    assign req_ready       = (state_reg == IDLE);
    assign m_valid         = (state_reg == DONE);
    assign m_mean_value    = mean_reg;
    assign m_last_in_slice = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            case (state_reg)
                IDLE: begin
                    if (req_valid) begin
                        last_reg <= req.last;
                        neg_reg  <= req.sum[SUM_W-1];
                        den_reg  <= req.count;
                        dvd_reg  <= {mag, {FRAC_BITS{1'b0}}};
                        rem_reg  <= '0;
                        step_reg <= '0;
                        if (req.count == COUNT_W'(1)) begin
                            mean_reg  <= MEAN_W'(scaled);
                            state_reg <= DONE;
                        end else begin
                            state_reg <= BUSY;
                        end
                    end
                end
                BUSY: begin
                    rem_reg  <= rem_nx;
                    dvd_reg  <= dvd_nx;
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                        mean_reg  <= MEAN_W'(q_s);
                        state_reg <= DONE;
                    end
                end
                DONE: begin
                    if (m_ready) begin
                        state_reg <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        req_valid && req_ready |=> !req_ready)
        else $error("divider took a second request while busy");

    a_nonzero_den: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BUSY |-> den_reg != '0)
        else $error("divide by zero count");
`endif

endmodule

>>> hw/rtl/block_average_downsample_xy.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_average_downsample_xy
// 2D box-filter binning of a raster voxel stream via a column sum RAM.
// ----------------------------------------------------------------------------
// Flow: a block-closing voxel passes the accumulate stage into the divider;
//   a one-voxel block bypasses the 32-step serial divider, any other block
//   runs through it before its mean is presented on the result port.
// Throughput: 1 voxel per cycle while no block-closing voxel waits for the
//   divider; a block-closing voxel holds the divider until its mean transfer.
// Reset: synchronous active-low aresetn clears counters, handshakes and
//   config (factor 1, 1024 x 1024); the sum RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module block_average_downsample_xy (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [bavg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bavg_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [bavg_pkg::SAMPLE_BITS-1:0] s_voxel_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [bavg_pkg::MEAN_W-1:0]   m_mean_value,
    output logic                                 m_last_in_slice
);
    import bavg_pkg::*;

    bavg_tag_t     tag;
    bavg_tag_t     b_tag_reg;
    bavg_div_req_t div_req;
    logic          b_valid_reg;
    logic signed [SAMPLE_BITS-1:0] b_voxel_reg;

    logic              accept, b_go, div_ready, ram_we;
    logic [SUM_W-1:0]  ram_rdata;
    logic              lw_valid_reg;
    logic [POS_W-1:0]  lw_addr_reg;
    logic signed [SUM_W-1:0] lw_data_reg;
    logic signed [SUM_W-1:0] old_sum, new_sum, voxel_ext;

    assign b_go    = !b_tag_reg.emit || div_ready;
    assign s_ready = !b_valid_reg || b_go;
    assign accept  = s_valid && s_ready;
    assign ram_we  = b_valid_reg && b_go;

    bavg_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .advance   (accept),
        .tag       (tag)
    );

    bavg_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_sum_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (b_tag_reg.addr),
        .wdata (new_sum),
        .re    (accept),
        .raddr (tag.addr),
        .rdata (ram_rdata)
    );

    // forward the last write, which the RAM read of the next voxel may miss
    always_comb begin
        voxel_ext = SUM_W'(b_voxel_reg);
        old_sum   = (lw_valid_reg && lw_addr_reg == b_tag_reg.addr) ?
                    lw_data_reg : signed'(ram_rdata);
        new_sum   = b_tag_reg.first_row ? voxel_ext : old_sum + voxel_ext;

        div_req.sum   = new_sum;
        div_req.count = b_tag_reg.count;
        div_req.last  = b_tag_reg.last_slice;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg  <= 1'b0;
            lw_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                b_valid_reg <= 1'b1;
            end else if (b_go) begin
                b_valid_reg <= 1'b0;
            end
            if (ram_we) begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_tag_reg   <= tag;
            b_voxel_reg <= s_voxel_value;
        end
        if (ram_we) begin
            lw_addr_reg <= b_tag_reg.addr;
            lw_data_reg <= new_sum;
        end
    end

    bavg_div u_div (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .req_valid       (b_valid_reg && b_tag_reg.emit),
        .req             (div_req),
        .req_ready       (div_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_mean_value    (m_mean_value),
        .m_last_in_slice (m_last_in_slice)
    );

`ifndef SYNTHESIS
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && !b_go |=> b_valid_reg && $stable(b_tag_reg.addr))
        else $error("accumulate stage lost its voxel during a stall");

    a_emit_needs_div: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we && b_tag_reg.emit |-> div_ready)
        else $error("block sum written back without divider transfer");
`endif

endmodule

>>> tb/tb_block_average_downsample_xy.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_block_average_downsample_xy
// Self-checking bench for the XY block averaging downsampler. A directed
// table covers reset defaults, sample extremes, register saturation, the
// ignored register index, partial edge blocks and truncation toward zero.
// Randomized phases follow, each with its own geometry and handshake
// pressure. Every mean transfer is checked against the expected mean of its
// typed directed row or else against an in-bench binning model.
// ----------------------------------------------------------------------------
module tb_block_average_downsample_xy;
    import bavg_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int NUM_PHASES   = 10;
    localparam int WIDE_PHASE   = 4;
    localparam int PAUSE_PHASE  = 2;
    localparam int SRC_IDLE_PCT [4] = '{0, 86, 0, 9};
    localparam int DST_STALL_PCT[4] = '{0, 0, 86, 9};
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [MEAN_W-1:0] mean;
        logic                     last;
    } mean_t;

    typedef enum logic {ROW_CFG, ROW_VOX} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        int                     value;
        bit                     typed;
        logic signed [MEAN_W-1:0] mean;
        logic                   last;
    } stim_row_t;

    // directed stimulus; typed rows carry their expected mean
    localparam int NUM_ROWS = 35;
    stim_row_t directed [NUM_ROWS] = '{
        '{ROW_VOX, REG_FACTOR,  32767, 1'b1, 24'sh7FFF00, 1'b0},
        '{ROW_VOX, REG_FACTOR, -32768, 1'b1, 24'sh800000, 1'b0},
        '{ROW_VOX, REG_FACTOR,      0, 1'b1, 24'sh000000, 1'b0},
        '{ROW_VOX, REG_FACTOR,     -1, 1'b1, 24'shFFFF00, 1'b0},
        '{ROW_VOX, REG_FACTOR,      1, 1'b1, 24'sh000100, 1'b0},
        '{ROW_CFG, REG_FACTOR,      0, 1'b0, 24'sh0, 1'b0},
        '{ROW_CFG, REG_WIDTH,       0, 1'b0, 24'sh0, 1'b0},
        '{ROW_CFG, REG_HEIGHT,      0, 1'b0, 24'sh0, 1'b0},
        '{ROW_VOX, REG_FACTOR,  32767, 1'b1, 24'sh7FFF00, 1'b1},
        '{ROW_VOX, REG_FACTOR, -32768, 1'b1, 24'sh800000, 1'b1},
        '{ROW_CFG, REG_FACTOR,      2, 1'b0, 24'sh0, 1'b0},
        '{ROW_CFG, REG_WIDTH,       3, 1'b0, 24'sh0, 1'b0},
        '{ROW_CFG, REG_HEIGHT,      2, 1'b0, 24'sh0, 1'b0},
        '{ROW_VOX, REG_FACTOR,    100, 1'b0, 24'sh0, 1'b0},
        '{ROW_VOX, REG_FACTOR,     -7, 1'b0, 24'sh0, 1'b0},
        '{ROW_VOX, REG_FACTOR,  32767, 1'b0, 24'sh0, 1'b0},
        '{ROW_CFG, REG_UNUSED,      5, 1'b0, 24'sh0, 1'b0},
        '{ROW_VOX, REG_FACTOR,      5, 1'b0, 24'sh0, 1'b0},
        '{ROW_VOX, REG_FACTOR,      9, 1'b0, 24'sh0, 1'b0},
        '{ROW_VOX, REG_FACTOR, -32768, 1'b0, 24'sh0, 1'b0},
        '{ROW_CFG, REG_FACTOR,   2047, 1'b0, 24'sh0, 1'b0},
        '{ROW_CFG, REG_WIDTH,    2047, 1'b0, 24'sh0, 1'b0},
        '{ROW_CFG, REG_HEIGHT,   2047, 1'b0, 24'sh0, 1'b0},
        '{ROW_CFG, REG_FACTOR,      3, 1'b0, 24'sh0, 1'b0},
        '{ROW_CFG, REG_WIDTH,       3, 1'b0, 24'sh0, 1'b0},
        '{ROW_CFG, REG_HEIGHT,      1, 1'b0, 24'sh0, 1'b0},
        '{ROW_VOX, REG_FACTOR,     -1, 1'b0, 24'sh0, 1'b0},
        '{ROW_VOX, REG_FACTOR,      0, 1'b0, 24'sh0, 1'b0},
        '{ROW_VOX, REG_FACTOR,      0, 1'b0, 24'sh0, 1'b0},
        '{ROW_CFG, REG_WIDTH,       2, 1'b0, 24'sh0, 1'b0},
        '{ROW_CFG, REG_HEIGHT,      2, 1'b0, 24'sh0, 1'b0},
        '{ROW_VOX, REG_FACTOR, -32768, 1'b0, 24'sh0, 1'b0},
        '{ROW_VOX, REG_FACTOR, -32768, 1'b0, 24'sh0, 1'b0},
        '{ROW_VOX, REG_FACTOR, -32768, 1'b0, 24'sh0, 1'b0},
        '{ROW_VOX, REG_FACTOR, -32768, 1'b0, 24'sh0, 1'b0}
    };

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [CFG_W-1:0]              cfg_wdata = '0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_voxel_value = '0;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    logic signed [MEAN_W-1:0]      m_mean_value;
    logic                          m_last_in_slice;

    // binning model state
    longint col_sums [MAX_WIDTH];
    int     x_pos, y_pos, col_in_blk, row_in_blk, blk_col;
    int     cur_factor, cur_width, cur_height;

    mean_t       pending_means[$];
    int          src_idle_pct  = 0;
    int          dst_stall_pct = 0;
    int          fail_count    = 0;
    int          mean_count    = 0;
    int          voxel_count   = 0;
    int          write_count   = 0;
    int unsigned cycle_count   = 0;

    block_average_downsample_xy i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_voxel_value   (s_voxel_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_mean_value    (m_mean_value),
        .m_last_in_slice (m_last_in_slice)
    );

    always #10 aclk = ~aclk;

    function automatic int clamp_to(int unsigned value, int lo, int hi);
        if (value < lo) return lo;
        if (value > hi) return hi;
        return value;
    endfunction

    function automatic void restart_scan();
        x_pos      = 0;
        y_pos      = 0;
        col_in_blk = 0;
        row_in_blk = 0;
        blk_col    = 0;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        if (idx == REG_FACTOR) begin
            cur_factor = clamp_to(value, 1, MAX_FACTOR);
        end else if (idx == REG_WIDTH) begin
            cur_width = clamp_to(value, 1, MAX_WIDTH);
        end else if (idx == REG_HEIGHT) begin
            cur_height = clamp_to(value, 1, HEIGHT_LIMIT);
        end else begin
            return;
        end
        restart_scan();
    endfunction

    // accumulate one voxel; returns 1 when it closes a block
    function automatic bit bin_voxel(logic signed [SAMPLE_BITS-1:0] v, output mean_t res);
        int     slot, cols, rows;
        longint cnt, avg;
        bit     end_col, end_row, emit;
        slot = blk_col % MAX_WIDTH;
        if (row_in_blk == 0) col_sums[slot] = v;
        else col_sums[slot] += v;
        end_col = (col_in_blk + 1 >= cur_factor) || (x_pos + 1 >= cur_width);
        end_row = (row_in_blk + 1 >= cur_factor) || (y_pos + 1 >= cur_height);
        emit    = end_col && end_row;
        res     = '0;
        if (emit) begin
            cols = cur_width - (x_pos - col_in_blk);
            rows = cur_height - (y_pos - row_in_blk);
            if (cols > cur_factor) cols = cur_factor;
            if (rows > cur_factor) rows = cur_factor;
            cnt = cols * rows;
            if (cnt < 1) cnt = 1;
            avg = (col_sums[slot] * 256) / cnt;
            res.mean = avg[MEAN_W-1:0];
            res.last = (x_pos + 1 >= cur_width) && (y_pos + 1 >= cur_height);
        end
        col_in_blk++;
        if (col_in_blk >= cur_factor) begin
            col_in_blk = 0;
            blk_col++;
        end
        x_pos++;
        if (x_pos >= cur_width) begin
            x_pos      = 0;
            col_in_blk = 0;
            blk_col    = 0;
            row_in_blk++;
            if (row_in_blk >= cur_factor) row_in_blk = 0;
            y_pos++;
            if (y_pos >= cur_height) begin
                y_pos      = 0;
                row_in_blk = 0;
            end
        end
        return emit;
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
        s_valid <= 1'b0;
        while (pending_means.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        apply_register(idx, value & ((1 << CFG_W) - 1));
        write_count++;
    endtask

    task automatic send_voxel(input logic signed [SAMPLE_BITS-1:0] v, input bit typed,
                              input mean_t typed_res);
        mean_t res;
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid       <= 1'b1;
        s_voxel_value <= v;
        do @(posedge aclk); while (!s_ready);
        voxel_count++;
        if (bin_voxel(v, res)) pending_means.push_back(typed ? typed_res : res);
    endtask

    // result side: random stall and compare
    always @(posedge aclk) begin
        mean_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_means.size() == 0) begin
                $error("unexpected mean transfer: mean_value %0d last_in_slice %0d",
                       m_mean_value, m_last_in_slice);
                fail_count++;
            end else begin
                want = pending_means.pop_front();
                mean_count++;
                if (m_mean_value !== want.mean) begin
                    $error("mean_value: expected %0d, got %0d", want.mean, m_mean_value);
                    fail_count++;
                end
                if (m_last_in_slice !== want.last) begin
                    $error("last_in_slice: expected %0d, got %0d", want.last,
                           m_last_in_slice);
                    fail_count++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= dst_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("block_average_downsample_xy verification failed");
            $finish;
        end
    end

    initial begin
        int fac, wid, hgt, n_vox, style;
        logic signed [SAMPLE_BITS-1:0] v;
        cur_factor = 1;
        cur_width  = MAX_WIDTH;
        cur_height = HEIGHT_LIMIT;
        restart_scan();
        foreach (col_sums[i]) col_sums[i] = 0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_CFG)
                write_register(directed[i].idx, directed[i].value);
            else
                send_voxel(directed[i].value[SAMPLE_BITS-1:0], directed[i].typed,
                           {directed[i].mean, directed[i].last});
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == WIDE_PHASE) begin
                // one long single-row slice, then the start of the next
                fac   = $urandom_range(12, 16);
                wid   = $urandom_range(400, 440);
                hgt   = 1;
                n_vox = wid + 5;
            end else begin
                fac   = ($urandom_range(7) == 0) ? $urandom_range(2047) : $urandom_range(1, 16);
                wid   = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(1, 20);
                hgt   = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(1, 12);
                n_vox = clamp_to(wid * hgt * 2, 30, 90);
            end
            style = $urandom_range(5);
            write_register(REG_FACTOR, fac);
            write_register(REG_WIDTH, wid);
            write_register(REG_HEIGHT, hgt);
            src_idle_pct  = SRC_IDLE_PCT[p % 4];
            dst_stall_pct = DST_STALL_PCT[p % 4];
            for (int n = 0; n < n_vox; n++) begin
                if (p == PAUSE_PHASE && n == n_vox / 2) begin
                    s_valid <= 1'b0;
                    @(posedge aclk);
                    while (pending_means.size() != 0) @(posedge aclk);
                end
                case (style)
                    3:       v = ($urandom_range(7) != 0) ? 16'sh7FFF : 16'($urandom);
                    4:       v = ($urandom_range(7) != 0) ? 16'sh8000 : 16'($urandom);
                    5:       v = 16'($urandom_range(6) - 3);
                    default: v = 16'($urandom);
                endcase
                send_voxel(v, 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_means.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Streamed %0d voxel transfers through %0d register writes; %0d block means",
                 voxel_count, write_count, mean_count);
        $display("checked under mixed sender gaps and receiver stalls.");
        if (fail_count == 0 && pending_means.size() == 0)
            $display("block_average_downsample_xy verification clean");
        else
            $display("block_average_downsample_xy verification failed");
        $finish;
    end

endmodule
